[sv/ossvf_pkg.sv]
// types, constants and register map shared by the oversampled state-variable filter
`default_nettype none

package ossvf_pkg;

	localparam int CUTOFF_W   = 15;
	localparam int DAMP_W     = 15;
	localparam int ITER_W     = 6;
	localparam int MODE_W     = 3;
	localparam int COEF_W     = 16;
	localparam int W_FRAC     = 16;
	localparam int D_FRAC     = 14;
	localparam int EXTRA_FRAC = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 15'd0;
	localparam logic [DAMP_W-1:0]   DAMP_RESET   = 15'd23173;
	localparam logic [ITER_W-1:0]   ITER_RESET   = 6'd5;
	localparam logic [MODE_W-1:0]   MODE_RESET   = 3'd1;

	localparam logic [MODE_W-1:0] MODE_SILENT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOWPASS  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BANDPASS = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HIGHPASS = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NOTCH    = 3'd4;

	typedef enum logic [1:0] {
		REG_CUTOFF,
		REG_DAMPING,
		REG_ITERATIONS,
		REG_MODE
	} reg_idx_t;

	typedef struct packed {
		logic [CUTOFF_W-1:0] cutoff;
		logic [DAMP_W-1:0]   damping;
		logic [ITER_W-1:0]   iterations;
		logic [MODE_W-1:0]   mode;
	} cfg_t;

	typedef enum logic [1:0] {
		MUL_W_BP,
		MUL_W_HP,
		MUL_D_BP
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_BP,
		ST_UPD_LP,
		ST_UPD_BP,
		ST_MUL_D,
		ST_UPD_HP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load_x;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     upd_lp;
		logic     upd_bp;
		logic     upd_hp;
		logic     out_load;
	} dp_cmd_t;

endpackage

`default_nettype wire

[sv/ossvf_regs.sv]
// apb configuration registers of the oversampled state-variable filter
`default_nettype none

module ossvf_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ossvf_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ossvf_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ossvf_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                  pready,
	output ossvf_pkg::cfg_t                       cfg
);

	ossvf_pkg::cfg_t     cfg_q;
	ossvf_pkg::reg_idx_t idx;
	logic                wr_en;

	assign idx    = ossvf_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff     <= ossvf_pkg::CUTOFF_RESET;
			cfg_q.damping    <= ossvf_pkg::DAMP_RESET;
			cfg_q.iterations <= ossvf_pkg::ITER_RESET;
			cfg_q.mode       <= ossvf_pkg::MODE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				ossvf_pkg::REG_CUTOFF: begin
					cfg_q.cutoff <= pwdata[ossvf_pkg::CUTOFF_W-1:0];
				end
				ossvf_pkg::REG_DAMPING: begin
					cfg_q.damping <= pwdata[ossvf_pkg::DAMP_W-1:0];
				end
				ossvf_pkg::REG_ITERATIONS: begin
					cfg_q.iterations <= pwdata[ossvf_pkg::ITER_W-1:0];
				end
				ossvf_pkg::REG_MODE: begin
					cfg_q.mode <= pwdata[ossvf_pkg::MODE_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ossvf_pkg::REG_CUTOFF:     prdata = ossvf_pkg::APB_DATA_W'(cfg_q.cutoff);
			ossvf_pkg::REG_DAMPING:    prdata = ossvf_pkg::APB_DATA_W'(cfg_q.damping);
			ossvf_pkg::REG_ITERATIONS: prdata = ossvf_pkg::APB_DATA_W'(cfg_q.iterations);
			ossvf_pkg::REG_MODE:       prdata = ossvf_pkg::APB_DATA_W'(cfg_q.mode);
		endcase
	end

endmodule

`default_nettype wire

[sv/ossvf_ctrl.sv]
// sequencing state machine of the oversampled state-variable filter
`default_nettype none

module ossvf_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ossvf_pkg::ITER_W-1:0]    iterations,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output ossvf_pkg::dp_cmd_t              cmd
);

	ossvf_pkg::state_t             state_q;
	ossvf_pkg::state_t             state_d;
	logic [ossvf_pkg::ITER_W-1:0]  iter_q;
	logic                          out_valid_q;
	logic                          last_iter;

	assign last_iter = (iter_q == (iterations - ossvf_pkg::ITER_W'(1)));
	assign m_tvalid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ossvf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.load_x) begin
			iter_q <= '0;
		end else if (cmd.upd_hp && !last_iter) begin
			iter_q <= iter_q + ossvf_pkg::ITER_W'(1);
		end
	end

	// result register, a new load wins over the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ossvf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_x = 1'b1;
					if (iterations == '0) begin
						state_d = ossvf_pkg::ST_DONE;
					end else begin
						state_d = ossvf_pkg::ST_MUL_BP;
					end
				end
			end
			ossvf_pkg::ST_MUL_BP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ossvf_pkg::MUL_W_BP;
				state_d     = ossvf_pkg::ST_UPD_LP;
			end
			ossvf_pkg::ST_UPD_LP: begin
				cmd.upd_lp  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ossvf_pkg::MUL_W_HP;
				state_d     = ossvf_pkg::ST_UPD_BP;
			end
			ossvf_pkg::ST_UPD_BP: begin
				cmd.upd_bp = 1'b1;
				state_d    = ossvf_pkg::ST_MUL_D;
			end
			ossvf_pkg::ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ossvf_pkg::MUL_D_BP;
				state_d     = ossvf_pkg::ST_UPD_HP;
			end
			ossvf_pkg::ST_UPD_HP: begin
				cmd.upd_hp = 1'b1;
				if (last_iter) begin
					state_d = ossvf_pkg::ST_DONE;
				end else begin
					// bandpass is final here, so the next lowpass product starts now
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = ossvf_pkg::MUL_W_BP;
					state_d     = ossvf_pkg::ST_UPD_LP;
				end
			end
			ossvf_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ossvf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ossvf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/ossvf_dp.sv]
// integrators, shared multiplier and output stage of the oversampled state-variable filter
`default_nettype none

module ossvf_dp #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ossvf_pkg::cfg_t           cfg,
	input  ossvf_pkg::dp_cmd_t        cmd,
	input  logic [SAMPLE_WIDTH-1:0]   sample_in,
	output logic [SAMPLE_WIDTH-1:0]   sample_out
);

	localparam int PROD_W = ACC_WIDTH + ossvf_pkg::COEF_W;
	localparam int XS_W   = SAMPLE_WIDTH + ossvf_pkg::EXTRA_FRAC;
	localparam int BASE_W = (ACC_WIDTH > XS_W) ? ACC_WIDTH : XS_W;
	localparam int SUM_W  = BASE_W + 4;
	localparam int TAP_W  = ((ACC_WIDTH + 1 > XS_W) ? ACC_WIDTH + 1 : XS_W) + 1;
	localparam int Y_W    = TAP_W - ossvf_pkg::EXTRA_FRAC;

	logic signed [ACC_WIDTH-1:0]     lp_q;
	logic signed [ACC_WIDTH-1:0]     bp_q;
	logic signed [ACC_WIDTH-1:0]     hp_q;
	logic signed [SAMPLE_WIDTH-1:0]  x_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic [SAMPLE_WIDTH-1:0]         out_q;

	logic signed [ACC_WIDTH-1:0]       mul_a;
	logic signed [ossvf_pkg::COEF_W-1:0] mul_b;
	logic signed [SUM_W-1:0]           prod_w;
	logic signed [SUM_W-1:0]           prod_d;
	logic signed [SUM_W-1:0]           x_ext;
	logic signed [SUM_W-1:0]           lp_sum;
	logic signed [SUM_W-1:0]           bp_sum;
	logic signed [SUM_W-1:0]           hp_sum;
	logic signed [TAP_W-1:0]           tap;
	logic signed [Y_W-1:0]             tap_sh;

	function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [SUM_W-1:0] v);
		logic [SUM_W-ACC_WIDTH:0] top;
		logic [ACC_WIDTH-1:0]     r;
		top = v[SUM_W-1:ACC_WIDTH-1];
		if ((&top) || !(|top)) begin
			r = v[ACC_WIDTH-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(ACC_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_WIDTH-1:0] sat_out(input logic [Y_W-1:0] v);
		logic [Y_W-SAMPLE_WIDTH:0] top;
		logic [SAMPLE_WIDTH-1:0]   r;
		top = v[Y_W-1:SAMPLE_WIDTH-1];
		if ((&top) || !(|top)) begin
			r = v[SAMPLE_WIDTH-1:0];
		end else if (v[Y_W-1]) begin
			r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		mul_a = bp_q;
		mul_b = $signed({1'b0, cfg.cutoff});
		unique case (cmd.mul_sel)
			ossvf_pkg::MUL_W_BP: begin
				mul_a = bp_q;
				mul_b = $signed({1'b0, cfg.cutoff});
			end
			ossvf_pkg::MUL_W_HP: begin
				mul_a = hp_q;
				mul_b = $signed({1'b0, cfg.cutoff});
			end
			ossvf_pkg::MUL_D_BP: begin
				mul_a = bp_q;
				mul_b = $signed({1'b0, cfg.damping});
			end
			default: begin
				mul_a = bp_q;
				mul_b = $signed({1'b0, cfg.cutoff});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= $signed(sample_in);
		end
	end

	// products scaled down by arithmetic shift, rounding towards minus infinity
	assign prod_w = SUM_W'($signed(prod_q[PROD_W-1:ossvf_pkg::W_FRAC]));
	assign prod_d = SUM_W'($signed(prod_q[PROD_W-1:ossvf_pkg::D_FRAC]));
	assign x_ext  = SUM_W'($signed({x_q, {ossvf_pkg::EXTRA_FRAC{1'b0}}}));
	assign lp_sum = SUM_W'(lp_q) - prod_w;
	assign bp_sum = SUM_W'(bp_q) - prod_w;
	assign hp_sum = prod_d - SUM_W'(lp_q) - x_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			bp_q <= '0;
			hp_q <= '0;
		end else begin
			if (cmd.upd_lp) begin
				lp_q <= $signed(sat_acc(lp_sum));
			end
			if (cmd.upd_bp) begin
				bp_q <= $signed(sat_acc(bp_sum));
			end
			if (cmd.upd_hp) begin
				hp_q <= $signed(sat_acc(hp_sum));
			end
		end
	end

	always_comb begin
		unique case (cfg.mode)
			ossvf_pkg::MODE_LOWPASS:  tap = TAP_W'(lp_q);
			ossvf_pkg::MODE_BANDPASS: tap = TAP_W'(bp_q);
			ossvf_pkg::MODE_HIGHPASS: tap = TAP_W'(hp_q);
			ossvf_pkg::MODE_NOTCH:    tap = TAP_W'(hp_q) + TAP_W'(lp_q);
			default:                  tap = '0;
		endcase
	end

	assign tap_sh = tap[TAP_W-1:ossvf_pkg::EXTRA_FRAC];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= sat_out(tap_sh);
		end
	end

	assign sample_out = out_q;

endmodule

`default_nettype wire

[sv/oversampled_state_variable_filter_unit.sv]
// top level of the oversampled state-variable filter
`default_nettype none

// Oversampled state-variable filter. Each sample taken on the s_ stream is run through
// 'iterations' passes of a lowpass/bandpass/highpass integrator loop; the output picked
// by the mode register (a tap, the notch sum or zero) leaves on the m_ stream saturated to
// the sample width. One multiplier is shared by the three dependent products of a pass, so
// a pass steps through UPD_LP, UPD_BP, MUL_D and UPD_HP, and no sample is taken while one
// is in work. A finished sample waits in the output register, and the next one is only
// taken after it has moved there. Coefficients are to be written over APB while the filter
// is idle, which the block itself does not enforce: cutoff 0x0, damping 0x4, iterations 0x8, mode 0xC.
module oversampled_state_variable_filter_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ossvf_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ossvf_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ossvf_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                  pready,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample_in
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata    // sample_out
);

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	ossvf_pkg::cfg_t           cfg;
	ossvf_pkg::dp_cmd_t        cmd;
	logic [SAMPLE_WIDTH-1:0]   sample_out;

	ossvf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ossvf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.iterations (cfg.iterations),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cmd        (cmd)
	);

	ossvf_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sample_in  (s_tdata[SAMPLE_WIDTH-1:0]),
		.sample_out (sample_out)
	);

	assign m_tdata = DATA_W'(sample_out);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a sample is still in work");

	a_no_update_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.upd_lp || cmd.upd_bp || cmd.upd_hp))
		else $error("integrator update while idle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before transfer");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not offered");

endmodule

`default_nettype wire

[sim/oversampled_state_variable_filter_unit_tb.sv]
// self-checking testbench for the oversampled state-variable filter: apb setup, streamed samples
`default_nettype none

module oversampled_state_variable_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW      = 16;
	localparam int AW      = 32;
	localparam int TDATA_W = ((SW + 7) / 8) * 8;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned RANDOM_ITEMS = 500;

	// modes with no tap of their own
	localparam logic [ossvf_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [ossvf_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [ossvf_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ossvf_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [ossvf_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [ossvf_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [TDATA_W-1:0] m_tdata;

	oversampled_state_variable_filter_unit #(
		.SAMPLE_WIDTH(SW),
		.ACC_WIDTH(AW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// filter settings and integrators as the filter should hold them
	logic [ossvf_pkg::CUTOFF_W-1:0] cut_w = ossvf_pkg::CUTOFF_RESET;
	logic [ossvf_pkg::DAMP_W-1:0] damp_d = ossvf_pkg::DAMP_RESET;
	logic [ossvf_pkg::ITER_W-1:0] iter_n = ossvf_pkg::ITER_RESET;
	logic [ossvf_pkg::MODE_W-1:0] mode_sel = ossvf_pkg::MODE_RESET;
	longint lp_acc = 0;
	longint bp_acc = 0;
	longint hp_acc = 0;

	logic [SW-1:0] sample_q[$];
	logic [SW-1:0] out_expect_q[$];
	int unsigned taken_cnt = 0;
	int unsigned offered_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;

	function automatic longint sat(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic [SW-1:0] svf_step(input logic [SW-1:0] smp);
		longint x;
		longint w;
		longint d;
		longint tap;
		longint y;
		x = longint'($signed(smp)) <<< ossvf_pkg::EXTRA_FRAC;
		w = longint'(cut_w);
		d = longint'(damp_d);
		for (int i = 0; i < int'(iter_n); i++) begin
			lp_acc = sat(lp_acc - ((w * bp_acc) >>> ossvf_pkg::W_FRAC), AW);
			bp_acc = sat(bp_acc - ((w * hp_acc) >>> ossvf_pkg::W_FRAC), AW);
			hp_acc = sat(((bp_acc * d) >>> ossvf_pkg::D_FRAC) - lp_acc - x, AW);
		end
		case (mode_sel)
			ossvf_pkg::MODE_LOWPASS: tap = lp_acc;
			ossvf_pkg::MODE_BANDPASS: tap = bp_acc;
			ossvf_pkg::MODE_HIGHPASS: tap = hp_acc;
			ossvf_pkg::MODE_NOTCH: tap = hp_acc + lp_acc;
			default: tap = 0;
		endcase
		y = sat(tap >>> ossvf_pkg::EXTRA_FRAC, SW);
		return y[SW-1:0];
	endfunction

	// transfers on both streams, checking and timeout
	always @(posedge clk) begin
		logic [SW-1:0] want;
		cycle_cnt++;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				out_expect_q.push_back(svf_step(s_tdata[SW-1:0]));
				taken_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (out_expect_q.size() == 0) begin
					$error("sample_out: expected none, actual %0d", $signed(m_tdata[SW-1:0]));
					err_cnt++;
				end else begin
					want = out_expect_q.pop_front();
					if (m_tdata[SW-1:0] !== want) begin
						$error("sample_out: expected %0d, actual %0d",
							$signed(want), $signed(m_tdata[SW-1:0]));
						err_cnt++;
					end
				end
			end
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// sample driver, bursts with random gaps
	int unsigned gap_left = 0;
	int unsigned burst_left = 1;
	always @(negedge clk) begin
		logic vld;
		logic [SW-1:0] dat;
		vld = s_tvalid;
		dat = s_tdata[SW-1:0];
		if (vld && taken_cnt == offered_cnt) begin
			vld = 1'b0;
			if (burst_left > 1)
				burst_left--;
			else begin
				burst_left = $urandom_range(1, 16);
				gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300)
					: $urandom_range(0, 8);
			end
		end
		if (!vld && arst_n) begin
			if (gap_left != 0)
				gap_left--;
			else if (sample_q.size() != 0) begin
				dat = sample_q.pop_front();
				vld = 1'b1;
				offered_cnt++;
			end
		end
		s_tvalid <= vld;
		s_tdata <= TDATA_W'(dat);
	end

	// receiver stalls, short and long, with long ready stretches
	int unsigned rx_left = 0;
	always @(negedge clk) begin
		if (rx_left != 0)
			rx_left--;
		else if (m_tready) begin
			m_tready <= 1'b0;
			rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400)
				: $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b1;
			rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 800)
				: $urandom_range(0, 30);
		end
	end

	task automatic reg_write(input ossvf_pkg::reg_idx_t idx,
		input logic [ossvf_pkg::APB_DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ossvf_pkg::APB_ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			ossvf_pkg::REG_CUTOFF: cut_w = val[ossvf_pkg::CUTOFF_W-1:0];
			ossvf_pkg::REG_DAMPING: damp_d = val[ossvf_pkg::DAMP_W-1:0];
			ossvf_pkg::REG_ITERATIONS: iter_n = val[ossvf_pkg::ITER_W-1:0];
			ossvf_pkg::REG_MODE: mode_sel = val[ossvf_pkg::MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_filter(input int unsigned cut, input int unsigned damp,
		input int unsigned iters, input logic [ossvf_pkg::MODE_W-1:0] mode);
		reg_write(ossvf_pkg::REG_CUTOFF, ossvf_pkg::APB_DATA_W'(cut));
		reg_write(ossvf_pkg::REG_DAMPING, ossvf_pkg::APB_DATA_W'(damp));
		reg_write(ossvf_pkg::REG_ITERATIONS, ossvf_pkg::APB_DATA_W'(iters));
		reg_write(ossvf_pkg::REG_MODE, ossvf_pkg::APB_DATA_W'(mode));
		@(posedge clk);
	endtask

	// hold the sender until every sample has come back
	task automatic drain();
		while (sample_q.size() != 0 || s_tvalid || out_expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		int unsigned rnd_cnt;
		int unsigned n;
		int unsigned cut;
		int unsigned damp;
		int unsigned iters;
		logic [ossvf_pkg::MODE_W-1:0] mode;
		logic [SW-1:0] smp;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings straight from reset
		sample_q.push_back(16'h7FFF);
		sample_q.push_back(16'h8000);
		sample_q.push_back(16'h0000);
		drain();

		set_filter(24707, 23173, 32, ossvf_pkg::MODE_LOWPASS);
		sample_q.push_back(16'h7FFF);
		sample_q.push_back(16'h7FFF);
		sample_q.push_back(16'h8000);
		sample_q.push_back(16'h8000);
		drain();

		set_filter(24707, 23173, 1, ossvf_pkg::MODE_BANDPASS);
		sample_q.push_back(16'h7FFF);
		sample_q.push_back(16'h8000);
		drain();

		// zero iterations leave the integrators alone
		set_filter(12000, 16384, 0, ossvf_pkg::MODE_HIGHPASS);
		sample_q.push_back(16'h0001);
		sample_q.push_back(16'hFFFF);
		drain();

		// largest coefficients and count, integrators saturate
		set_filter(32767, 32767, 63, ossvf_pkg::MODE_NOTCH);
		sample_q.push_back(16'h7FFF);
		sample_q.push_back(16'h8000);
		sample_q.push_back(16'h7FFF);
		drain();

		set_filter(20000, 0, 4, MODE_SPARE_5);
		sample_q.push_back(16'h03E8);
		drain();
		set_filter(20000, 0, 4, MODE_SPARE_6);
		sample_q.push_back(16'hAAAA);
		drain();
		set_filter(20000, 0, 4, MODE_SPARE_7);
		sample_q.push_back(16'h5555);
		drain();
		set_filter(0, 23173, 3, ossvf_pkg::MODE_SILENT);
		sample_q.push_back(16'h3039);
		drain();

		rnd_cnt = 0;
		smp = '0;
		while (rnd_cnt < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: cut = ($urandom_range(0, 1) == 0) ? 0 : 32767;
				1: cut = $urandom_range(0, 32767);
				default: cut = $urandom_range(0, 24707);
			endcase
			case ($urandom_range(0, 5))
				0: damp = ($urandom_range(0, 1) == 0) ? 0 : 32767;
				default: damp = $urandom_range(0, 32767);
			endcase
			case ($urandom_range(0, 7))
				0: iters = 0;
				1: iters = $urandom_range(32, 63);
				2: iters = $urandom_range(9, 31);
				default: iters = $urandom_range(1, 8);
			endcase
			mode = ($urandom_range(0, 4) == 0) ? ossvf_pkg::MODE_W'($urandom_range(0, 7))
				: ossvf_pkg::MODE_W'($urandom_range(1, 4));
			set_filter(cut, damp, iters, mode);
			n = $urandom_range(10, 40);
			for (int k = 0; k < int'(n); k++) begin
				case ($urandom_range(0, 9))
					0: smp = ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
					1, 2: ;
					3, 4: smp = SW'($signed($urandom_range(0, 512)) - 256);
					default: smp = SW'($urandom());
				endcase
				sample_q.push_back(smp);
			end
			rnd_cnt += n;
			drain();
		end

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
sv/ossvf_pkg.sv
sv/ossvf_regs.sv
sv/ossvf_ctrl.sv
sv/ossvf_dp.sv
sv/oversampled_state_variable_filter_unit.sv
sim/oversampled_state_variable_filter_unit_tb.sv
